/* sv/ymr_pkg.sv */
// ----------------------------------------------------------------------------
// ymr_pkg
// Types, codes and helpers shared by the YModem-CRC receiver modules.
// ----------------------------------------------------------------------------
package ymr_pkg;

   localparam int LONG_BLOCK_BYTES  = 1024;
   localparam int SHORT_BLOCK_BYTES = 128;
   localparam int SIZE_DIGITS_MAX   = 16;
   localparam int NAME_BYTES_MAX    = 256;

   localparam logic [7:0] B_SOH = 8'h01;
   localparam logic [7:0] B_STX = 8'h02;
   localparam logic [7:0] B_EOT = 8'h04;
   localparam logic [7:0] B_ACK = 8'h06;
   localparam logic [7:0] B_NAK = 8'h15;
   localparam logic [7:0] B_CA  = 8'h18;
   localparam logic [7:0] B_C   = 8'h43;
   localparam logic [7:0] B_ABU = 8'h41;
   localparam logic [7:0] B_ABL = 8'h61;

   localparam logic [1:0] CSR_START = 2'd0;
   localparam logic [1:0] CSR_CAP   = 2'd1;
   localparam logic [1:0] CSR_MAXE  = 2'd2;

   typedef enum logic [2:0] {
      PH_WAIT, PH_SEQ, PH_SEQC, PH_DATA, PH_CRCH, PH_CRCL, PH_CA2
   } phase_type;

   typedef enum logic [1:0] {HF_NAME, HF_SIZE, HF_DONE, HF_EMPTY} hfield_type;

   typedef enum logic [1:0] {
      K_REPLY = 2'd0, K_PAYLOAD = 2'd1, K_COMMIT = 2'd2, K_FINISH = 2'd3
   } kind_type;

   localparam logic [2:0] ST_COMPLETE = 3'd0;
   localparam logic [2:0] ST_CANCEL   = 3'd1;
   localparam logic [2:0] ST_ERRORS   = 3'd2;
   localparam logic [2:0] ST_TOOBIG   = 3'd3;
   localparam logic [2:0] ST_ABORT    = 3'd4;

   // one result beat
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  value;
      logic [9:0]  payload_offset;
      logic [23:0] write_address;
      logic [10:0] write_length;
      logic [2:0]  status;
      logic [31:0] size_report;
      logic        last;
   } result_type;

   localparam int QDEPTH = 4;
   localparam int QAW    = $clog2(QDEPTH);

   function automatic logic [15:0] crc_byte(input logic [15:0] c_in,
                                            input logic [7:0] b);
      logic [15:0] c;
      c = c_in ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

   function automatic result_type mk_reply(input logic [7:0] b);
      result_type r;
      r = '0;
      r.kind = K_REPLY;
      r.value = b;
      return r;
   endfunction

endpackage

/* sv/ymodem_crc_packet_receiver.sv */
// ----------------------------------------------------------------------------
// ymodem_crc_packet_receiver
// YModem-CRC receive engine with a decoupled result queue.
// ----------------------------------------------------------------------------
// The protocol engine handles each byte or timeout beat in the cycle it is
// accepted and pushes up to three result beats into a four-entry queue; the
// result port drains one beat a cycle while rsp_tready is high, the first
// in the cycle after the input beat. req_tready is low while fewer than
// three queue slots are free. With rsp_tready held high, items that give
// one beat each follow back to back; an item that gives two beats holds off
// the next until a beat has drained (a three-beat item ends the session).
// While rsp_tready is low the input waits as long as the queue stays that full.
module ymodem_crc_packet_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte
   input  logic        req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // value, payload_offset, write_address,
                                    // write_length, status, file size
   output logic [1:0]  rsp_tuser,   // kind
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   logic [1:0] n;
   ymr_pkg::result_type r0, r1, r2, ro;
   logic room, empty;

   assign req_tready = room;
   assign csr_ready = 1'b1;

   ymr_front u_front (
      .clock, .reset,
      .in_valid (req_tvalid && req_tready),
      .in_op    (req_tuser),
      .in_byte  (req_tdata),
      .csr_wr   (csr_valid),
      .csr_idx  (csr_index),
      .csr_data (csr_data),
      .out_n (n), .out_r0 (r0), .out_r1 (r1), .out_r2 (r2)
   );

   ymr_back u_back (
      .clock, .reset,
      .in_n (n), .in_r0 (r0), .in_r1 (r1), .in_r2 (r2),
      .room, .empty,
      .out_valid (rsp_tvalid), .out_ready (rsp_tready), .out_r (ro)
   );

   assign rsp_tdata = {ro.size_report, ro.status, ro.write_length,
                       ro.write_address, ro.payload_offset, ro.value};
   assign rsp_tuser = ro.kind;
   assign rsp_tlast = ro.last;

   a_valid_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid == !empty) else $error("valid and empty disagree");
   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !$isunknown({rsp_tdata, rsp_tuser, rsp_tlast}))
      else $error("unknown result beat");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result beat dropped or changed while stalled");

endmodule

/* sv/ymr_front.sv */
// ----------------------------------------------------------------------------
// ymr_front
// Protocol engine: deframes packets, parses the header, makes up to three
// result beats per byte combinationally.
// ----------------------------------------------------------------------------
module ymr_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic                   in_op,
   input  logic [7:0]             in_byte,
   input  logic                   csr_wr,
   input  logic [1:0]             csr_idx,
   input  logic [31:0]            csr_data,
   output logic [1:0]             out_n,
   output ymr_pkg::result_type    out_r0,
   output ymr_pkg::result_type    out_r1,
   output ymr_pkg::result_type    out_r2
);

   logic [23:0] start_ff, start_in;
   logic [24:0] cap_ff, cap_in;
   logic [7:0]  maxe_ff, maxe_in;
   ymr_pkg::phase_type  phase_ff, phase_in;
   ymr_pkg::hfield_type hf_ff, hf_in;
   logic        long_ff, long_in, hseen_ff, hseen_in, begun_ff, begun_in;
   logic        fin_ff, fin_in, sv_ff, sv_in;
   logic [10:0] bc_ff, bc_in;
   logic [7:0]  seq_ff, seq_in, exp_ff, exp_in, err_ff, err_in;
   logic [15:0] crc_ff, crc_in, crx_ff, crx_in;
   logic [31:0] size_ff, size_in;
   logic [8:0]  fc_ff, fc_in;
   logic [23:0] na_ff, na_in;

   ymr_pkg::result_type r [3];
   logic [1:0] n;
   logic [7:0] e_tmp;
   logic [10:0] len;
   logic [35:0] prod;
   logic [15:0] crc_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0; cap_ff <= 25'h1000000; maxe_ff <= 8'd5;
         phase_ff <= ymr_pkg::PH_WAIT; hf_ff <= ymr_pkg::HF_NAME;
         long_ff <= 1'b0; hseen_ff <= 1'b0; begun_ff <= 1'b0; fin_ff <= 1'b0;
         sv_ff <= 1'b0; bc_ff <= '0; seq_ff <= '0; exp_ff <= '0; err_ff <= '0;
         crc_ff <= '0; crx_ff <= '0; size_ff <= '0; fc_ff <= '0; na_ff <= '0;
      end else begin
         start_ff <= start_in; cap_ff <= cap_in; maxe_ff <= maxe_in;
         phase_ff <= phase_in; hf_ff <= hf_in; long_ff <= long_in;
         hseen_ff <= hseen_in; begun_ff <= begun_in; fin_ff <= fin_in;
         sv_ff <= sv_in; bc_ff <= bc_in; seq_ff <= seq_in; exp_ff <= exp_in;
         err_ff <= err_in; crc_ff <= crc_in; crx_ff <= crx_in;
         size_ff <= size_in; fc_ff <= fc_in; na_ff <= na_in;
      end
   end

   assign len = long_ff ? 11'(ymr_pkg::LONG_BLOCK_BYTES)
                        : 11'(ymr_pkg::SHORT_BLOCK_BYTES);
   // size*10 plus the value of the digit
   assign prod = {4'd0, size_ff} * 36'd10 + {28'd0, in_byte - 8'h30};
   assign crc_full = {crx_ff[15:8], in_byte};

   always_comb begin
      start_in = start_ff; cap_in = cap_ff; maxe_in = maxe_ff;
      phase_in = phase_ff; hf_in = hf_ff; long_in = long_ff;
      hseen_in = hseen_ff; begun_in = begun_ff; fin_in = fin_ff; sv_in = sv_ff;
      bc_in = bc_ff; seq_in = seq_ff; exp_in = exp_ff; err_in = err_ff;
      crc_in = crc_ff; crx_in = crx_ff; size_in = size_ff; fc_in = fc_ff;
      na_in = na_ff;
      r[0] = '0; r[1] = '0; r[2] = '0; n = 2'd0; e_tmp = err_ff;

      if (csr_wr) begin
         case (csr_idx)
            ymr_pkg::CSR_START: begin
               start_in = csr_data[23:0];
               na_in = csr_data[23:0];
            end
            ymr_pkg::CSR_CAP:  cap_in = csr_data[24:0];
            ymr_pkg::CSR_MAXE: maxe_in = csr_data[7:0];
            default: ;
         endcase
      end

      if (in_valid && !fin_ff) begin
         logic do_err;
         do_err = 1'b0;
         if (in_op) begin
            do_err = 1'b1;
         end else begin
            unique case (phase_ff)
               ymr_pkg::PH_WAIT: begin
                  if (in_byte == ymr_pkg::B_SOH || in_byte == ymr_pkg::B_STX) begin
                     long_in = (in_byte == ymr_pkg::B_STX);
                     bc_in = '0; crc_in = '0; phase_in = ymr_pkg::PH_SEQ;
                  end else if (in_byte == ymr_pkg::B_EOT) begin
                     err_in = '0;
                     r[0] = ymr_pkg::mk_reply(ymr_pkg::B_ACK);
                     r[1] = ymr_pkg::mk_reply(ymr_pkg::B_C);
                     n = 2'd2; exp_in = '0; hseen_in = 1'b0;
                  end else if (in_byte == ymr_pkg::B_CA) begin
                     phase_in = ymr_pkg::PH_CA2;
                  end else if (in_byte == ymr_pkg::B_ABU || in_byte == ymr_pkg::B_ABL) begin
                     r[0] = ymr_pkg::mk_reply(ymr_pkg::B_CA);
                     r[1] = ymr_pkg::mk_reply(ymr_pkg::B_CA);
                     r[2].kind = ymr_pkg::K_FINISH; r[2].status = ymr_pkg::ST_ABORT;
                     r[2].size_report = size_ff; n = 2'd3; fin_in = 1'b1;
                  end else begin
                     do_err = 1'b1;
                  end
               end
               ymr_pkg::PH_SEQ: begin
                  seq_in = in_byte; phase_in = ymr_pkg::PH_SEQC;
               end
               ymr_pkg::PH_SEQC: begin
                  sv_in = ((in_byte ^ 8'hff) == seq_ff);
                  phase_in = ymr_pkg::PH_DATA;
               end
               ymr_pkg::PH_DATA: begin
                  if (hseen_ff) begin
                     r[0].kind = ymr_pkg::K_PAYLOAD; r[0].value = in_byte;
                     r[0].payload_offset = bc_ff[9:0]; n = 2'd1;
                  end else if (seq_ff == 8'd0) begin
                     if (bc_ff == 11'd0) begin
                        if (in_byte == 8'd0) hf_in = ymr_pkg::HF_EMPTY;
                        else begin
                           hf_in = ymr_pkg::HF_NAME; fc_in = 9'd1; size_in = '0;
                        end
                     end else if (hf_ff == ymr_pkg::HF_NAME) begin
                        if (in_byte == 8'd0 || fc_ff >= 9'(ymr_pkg::NAME_BYTES_MAX)) begin
                           hf_in = ymr_pkg::HF_SIZE; fc_in = '0;
                        end else fc_in = fc_ff + 9'd1;
                     end else if (hf_ff == ymr_pkg::HF_SIZE) begin
                        if (in_byte >= 8'h30 && in_byte <= 8'h39 &&
                            fc_ff < 9'(ymr_pkg::SIZE_DIGITS_MAX)) begin
                           size_in = (prod[35:32] != 4'd0) ? 32'hffffffff : prod[31:0];
                           fc_in = fc_ff + 9'd1;
                        end else hf_in = ymr_pkg::HF_DONE;
                     end
                  end
                  crc_in = ymr_pkg::crc_byte(crc_ff, in_byte);
                  bc_in = bc_ff + 11'd1;
                  if (bc_ff + 11'd1 >= len) phase_in = ymr_pkg::PH_CRCH;
               end
               ymr_pkg::PH_CRCH: begin
                  crx_in = {in_byte, 8'h00}; phase_in = ymr_pkg::PH_CRCL;
               end
               ymr_pkg::PH_CRCL: begin
                  crx_in = crc_full; phase_in = ymr_pkg::PH_WAIT;
                  if (!sv_ff) do_err = 1'b1;
                  else begin
                     err_in = '0;
                     if (seq_ff != exp_ff) begin
                        r[0] = ymr_pkg::mk_reply(ymr_pkg::B_NAK); n = 2'd1;
                     end else if (!hseen_ff) begin
                        if (hf_ff == ymr_pkg::HF_EMPTY) begin
                           r[0] = ymr_pkg::mk_reply(ymr_pkg::B_ACK);
                           r[1].kind = ymr_pkg::K_FINISH;
                           r[1].status = ymr_pkg::ST_COMPLETE;
                           r[1].size_report = size_ff; n = 2'd2; fin_in = 1'b1;
                        end else if ({1'b0, size_ff} + {9'd0, start_ff} + 33'd1 >
                                     {8'd0, cap_ff}) begin
                           r[0] = ymr_pkg::mk_reply(ymr_pkg::B_CA);
                           r[1] = ymr_pkg::mk_reply(ymr_pkg::B_CA);
                           r[2].kind = ymr_pkg::K_FINISH;
                           r[2].status = ymr_pkg::ST_TOOBIG;
                           r[2].size_report = size_ff; n = 2'd3; fin_in = 1'b1;
                        end else begin
                           r[0] = ymr_pkg::mk_reply(ymr_pkg::B_ACK);
                           r[1] = ymr_pkg::mk_reply(ymr_pkg::B_C); n = 2'd2;
                           hseen_in = 1'b1; exp_in = 8'd1; begun_in = 1'b1;
                        end
                     end else begin
                        begun_in = 1'b1;
                        if ({9'd0, na_ff} < {9'd0, start_ff} + {1'b0, size_ff}) begin
                           if (crc_full != crc_ff) begin
                              r[0] = ymr_pkg::mk_reply(ymr_pkg::B_NAK); n = 2'd1;
                           end else begin
                              r[0].kind = ymr_pkg::K_COMMIT;
                              r[0].write_address = na_ff; r[0].write_length = len;
                              r[1] = ymr_pkg::mk_reply(ymr_pkg::B_ACK); n = 2'd2;
                              na_in = na_ff + {13'd0, len};
                              exp_in = exp_ff + 8'd1;
                           end
                        end else begin
                           r[0] = ymr_pkg::mk_reply(ymr_pkg::B_ACK); n = 2'd1;
                           exp_in = exp_ff + 8'd1;
                        end
                     end
                  end
               end
               ymr_pkg::PH_CA2: begin
                  if (in_byte == ymr_pkg::B_CA) begin
                     phase_in = ymr_pkg::PH_WAIT; err_in = '0;
                     r[0] = ymr_pkg::mk_reply(ymr_pkg::B_ACK);
                     r[1].kind = ymr_pkg::K_FINISH; r[1].status = ymr_pkg::ST_CANCEL;
                     r[1].size_report = size_ff; n = 2'd2; fin_in = 1'b1;
                  end else do_err = 1'b1;
               end
               default: phase_in = ymr_pkg::PH_WAIT;
            endcase
         end
         if (do_err) begin
            phase_in = ymr_pkg::PH_WAIT;
            if (begun_ff && err_ff != 8'hff) e_tmp = err_ff + 8'd1;
            err_in = e_tmp;
            if (e_tmp > maxe_ff) begin
               r[0] = ymr_pkg::mk_reply(ymr_pkg::B_CA);
               r[1] = ymr_pkg::mk_reply(ymr_pkg::B_CA);
               r[2] = '0; r[2].kind = ymr_pkg::K_FINISH;
               r[2].status = ymr_pkg::ST_ERRORS; r[2].size_report = size_ff;
               n = 2'd3; fin_in = 1'b1;
            end else begin
               r[0] = ymr_pkg::mk_reply(ymr_pkg::B_C); r[1] = '0; r[2] = '0;
               n = 2'd1;
            end
         end
         if (n == 2'd1) r[0].last = 1'b1;
         if (n == 2'd2) r[1].last = 1'b1;
         if (n == 2'd3) r[2].last = 1'b1;
      end
   end

   assign out_n = n;
   assign out_r0 = r[0];
   assign out_r1 = r[1];
   assign out_r2 = r[2];

   a_fin_silent: assert property (@(posedge clock) disable iff (reset)
      fin_ff |-> out_n == 2'd0) else $error("results after finish");
   a_fin_sticky: assert property (@(posedge clock) disable iff (reset)
      fin_ff |=> fin_ff) else $error("finish flag cleared");
   a_last: assert property (@(posedge clock) disable iff (reset)
      out_n != 2'd0 |-> out_r0.last == (out_n == 2'd1))
      else $error("last flag misplaced");

endmodule

/* sv/ymr_back.sv */
// ----------------------------------------------------------------------------
// ymr_back
// Result queue: takes up to three beats a cycle, drains one beat a cycle while out_ready is high.
// ----------------------------------------------------------------------------
module ymr_back (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          in_n,
   input  ymr_pkg::result_type in_r0,
   input  ymr_pkg::result_type in_r1,
   input  ymr_pkg::result_type in_r2,
   output logic                room,
   output logic                empty,
   output logic                out_valid,
   input  logic                out_ready,
   output ymr_pkg::result_type out_r
);

   localparam int CW = ymr_pkg::QAW + 1;

   ymr_pkg::result_type mem_ff [ymr_pkg::QDEPTH];
   logic [ymr_pkg::QAW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic pop;

   assign pop = out_valid && out_ready;
   assign out_valid = (cnt_ff != '0);
   assign out_r = mem_ff[rp_ff];
   assign empty = (cnt_ff == '0);
   // three slots must be free before a new item is taken
   assign room = (cnt_ff <= CW'(ymr_pkg::QDEPTH - 3));

   always_comb begin
      wp_in = wp_ff + ymr_pkg::QAW'(in_n);
      rp_in = rp_ff + ymr_pkg::QAW'(pop);
      cnt_in = cnt_ff + CW'(in_n) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_n >= 2'd1) mem_ff[wp_ff] <= in_r0;
      if (in_n >= 2'd2) mem_ff[wp_ff + ymr_pkg::QAW'(1)] <= in_r1;
      if (in_n == 2'd3) mem_ff[wp_ff + ymr_pkg::QAW'(2)] <= in_r2;
   end

   a_noovf: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(ymr_pkg::QDEPTH)) else $error("queue overflow");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      in_n != 2'd0 |-> room) else $error("push without room");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(out_r))
      else $error("head beat changed while stalled");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// YModem-CRC receiver testbench
// Feeds byte and timeout beats through the request stream, predicts every
// reply, payload, commit and finish beat with its own protocol model, and
// checks the result stream beat by beat. Configuration changes between files.
// ----------------------------------------------------------------------------
module testbench;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [87:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = ymr_pkg::CSR_START;
   logic [31:0] csr_data = '0;

   ymodem_crc_packet_receiver u_dut (.*);

   always #5 clock = ~clock;

   // --- receiver model state ------------------------------------------------
   ymr_pkg::phase_type   rx_phase;
   ymr_pkg::hfield_type  hdr_part;
   logic        blk_long, hdr_done, seq_ok, begun, closed;
   logic [10:0] blk_pos;
   logic [7:0]  seq_got, seq_want, err_run;
   logic [15:0] crc_calc, crc_sent;
   logic [31:0] size_parsed;
   logic [8:0]  part_count;
   logic [23:0] flash_ptr;
   logic [23:0] base_addr = '0;
   logic [24:0] capacity = 25'h1000000;
   logic [7:0]  err_limit = 8'd5;

   ymr_pkg::result_type  step_beats[$];
   ymr_pkg::result_type  awaited[$];
   logic [8:0]  pending[$];     // {rx_byte, op}
   logic [7:0]  body[$];
   logic [8:0]  next_item;

   int unsigned errors = 0, cycles = 0, quiet_cycles = 0, beats_checked = 0;
   int unsigned items_sent = 0, queued = 0;
   logic        req_took = 1'b0;

   function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      logic        fb;
      r = c;
      for (int i = 7; i >= 0; i--) begin
         fb = r[15] ^ b[i];
         r = {r[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
      end
      return r;
   endfunction

   function automatic void put(ymr_pkg::kind_type k, logic [7:0] v, logic [9:0] off,
                               logic [23:0] a, logic [10:0] l, logic [2:0] st,
                               logic [31:0] fs);
      ymr_pkg::result_type r;
      r = '0;
      r.kind = k; r.value = v; r.payload_offset = off; r.write_address = a;
      r.write_length = l; r.status = st; r.size_report = fs;
      step_beats.push_back(r);
   endfunction

   function automatic void say(logic [7:0] b);
      put(ymr_pkg::K_REPLY, b, '0, '0, '0, '0, '0);
   endfunction

   function automatic void close_session(logic [2:0] st);
      put(ymr_pkg::K_FINISH, '0, '0, '0, '0, st, size_parsed);
      closed = 1'b1;
   endfunction

   function automatic void line_fault();
      rx_phase = ymr_pkg::PH_WAIT;
      if (begun && err_run != 8'hff) err_run++;
      if (err_run > err_limit) begin
         say(ymr_pkg::B_CA); say(ymr_pkg::B_CA); close_session(ymr_pkg::ST_ERRORS);
      end else begin
         say(ymr_pkg::B_C);
      end
   endfunction

   function automatic void parse_hdr(logic [10:0] off, logic [7:0] b);
      longint unsigned v;
      if (off == 0) begin
         if (b == 0) hdr_part = ymr_pkg::HF_EMPTY;
         else begin
            hdr_part = ymr_pkg::HF_NAME; part_count = 9'd1; size_parsed = '0;
         end
      end else if (hdr_part == ymr_pkg::HF_NAME) begin
         if (b == 0 || part_count >= ymr_pkg::NAME_BYTES_MAX) begin
            hdr_part = ymr_pkg::HF_SIZE; part_count = '0;
         end else part_count++;
      end else if (hdr_part == ymr_pkg::HF_SIZE) begin
         if (b >= "0" && b <= "9" && part_count < ymr_pkg::SIZE_DIGITS_MAX) begin
            v = longint'(size_parsed) * 10 + (b - "0");
            size_parsed = (v > 64'hffffffff) ? 32'hffffffff : v[31:0];
            part_count++;
         end else hdr_part = ymr_pkg::HF_DONE;
      end
   endfunction

   function automatic void packet_done();
      logic [10:0] len;
      len = blk_long ? 11'(ymr_pkg::LONG_BLOCK_BYTES) : 11'(ymr_pkg::SHORT_BLOCK_BYTES);
      rx_phase = ymr_pkg::PH_WAIT;
      if (!seq_ok) begin
         line_fault();
         return;
      end
      err_run = '0;
      if (seq_got != seq_want) begin
         say(ymr_pkg::B_NAK);
         return;
      end
      if (!hdr_done) begin
         if (hdr_part == ymr_pkg::HF_EMPTY) begin
            say(ymr_pkg::B_ACK); close_session(ymr_pkg::ST_COMPLETE);
         end else if (longint'(size_parsed) + base_addr + 1 > longint'(capacity)) begin
            say(ymr_pkg::B_CA); say(ymr_pkg::B_CA); close_session(ymr_pkg::ST_TOOBIG);
         end else begin
            say(ymr_pkg::B_ACK); say(ymr_pkg::B_C);
            hdr_done = 1'b1; seq_want = 8'd1; begun = 1'b1;
         end
         return;
      end
      begun = 1'b1;
      if (longint'(flash_ptr) < longint'(base_addr) + size_parsed) begin
         if (crc_sent != crc_calc) begin
            say(ymr_pkg::B_NAK);
            return;
         end
         put(ymr_pkg::K_COMMIT, '0, '0, flash_ptr, len, '0, '0);
         flash_ptr = flash_ptr + {13'd0, len};
      end
      say(ymr_pkg::B_ACK);
      seq_want++;
   endfunction

   function automatic void predict(logic op, logic [7:0] b);
      logic [10:0] len;
      ymr_pkg::result_type tail;
      len = blk_long ? 11'(ymr_pkg::LONG_BLOCK_BYTES) : 11'(ymr_pkg::SHORT_BLOCK_BYTES);
      step_beats.delete();
      if (closed) return;
      if (op) line_fault();
      else case (rx_phase)
         ymr_pkg::PH_WAIT: begin
            if (b == ymr_pkg::B_SOH || b == ymr_pkg::B_STX) begin
               blk_long = (b == ymr_pkg::B_STX); blk_pos = '0; crc_calc = '0;
               rx_phase = ymr_pkg::PH_SEQ;
            end else if (b == ymr_pkg::B_EOT) begin
               err_run = '0; say(ymr_pkg::B_ACK); say(ymr_pkg::B_C);
               seq_want = '0; hdr_done = 1'b0;
            end else if (b == ymr_pkg::B_CA) rx_phase = ymr_pkg::PH_CA2;
            else if (b == ymr_pkg::B_ABU || b == ymr_pkg::B_ABL) begin
               say(ymr_pkg::B_CA); say(ymr_pkg::B_CA); close_session(ymr_pkg::ST_ABORT);
            end else line_fault();
         end
         ymr_pkg::PH_SEQ: begin
            seq_got = b; rx_phase = ymr_pkg::PH_SEQC;
         end
         ymr_pkg::PH_SEQC: begin
            seq_ok = ((b ^ 8'hff) == seq_got); rx_phase = ymr_pkg::PH_DATA;
         end
         ymr_pkg::PH_DATA: begin
            if (hdr_done) put(ymr_pkg::K_PAYLOAD, b, blk_pos[9:0], '0, '0, '0, '0);
            else if (seq_got == 0) parse_hdr(blk_pos, b);
            crc_calc = crc16_step(crc_calc, b);
            blk_pos++;
            if (blk_pos >= len) rx_phase = ymr_pkg::PH_CRCH;
         end
         ymr_pkg::PH_CRCH: begin
            crc_sent = {b, 8'h00}; rx_phase = ymr_pkg::PH_CRCL;
         end
         ymr_pkg::PH_CRCL: begin
            crc_sent[7:0] = b; packet_done();
         end
         ymr_pkg::PH_CA2: begin
            if (b == ymr_pkg::B_CA) begin
               rx_phase = ymr_pkg::PH_WAIT; err_run = '0; say(ymr_pkg::B_ACK);
               close_session(ymr_pkg::ST_CANCEL);
            end else line_fault();
         end
         default: rx_phase = ymr_pkg::PH_WAIT;
      endcase
      if (step_beats.size() > 0) begin
         tail = step_beats.pop_back();
         tail.last = 1'b1;
         step_beats.push_back(tail);
      end
   endfunction

   // --- checking ------------------------------------------------------------
   task automatic mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_v, got_v);
      errors++;
   endtask

   task automatic check_beat();
      ymr_pkg::result_type e;
      if (awaited.size() == 0) begin
         $display("%0t: unexpected result beat %h", $time, rsp_tdata);
         errors++;
         return;
      end
      e = awaited.pop_front();
      beats_checked++;
      if (e.kind != rsp_tuser) mismatch("kind", e.kind, rsp_tuser);
      if (e.value != rsp_tdata[7:0]) mismatch("value", e.value, rsp_tdata[7:0]);
      if (e.payload_offset != rsp_tdata[17:8])
         mismatch("payload_offset", e.payload_offset, rsp_tdata[17:8]);
      if (e.write_address != rsp_tdata[41:18])
         mismatch("write_address", e.write_address, rsp_tdata[41:18]);
      if (e.write_length != rsp_tdata[52:42])
         mismatch("write_length", e.write_length, rsp_tdata[52:42]);
      if (e.status != rsp_tdata[55:53]) mismatch("status", e.status, rsp_tdata[55:53]);
      if (e.size_report != rsp_tdata[87:56])
         mismatch("file size", e.size_report, rsp_tdata[87:56]);
      if (e.last != rsp_tlast) mismatch("last", e.last, rsp_tlast);
   endtask

   // --- monitor, model update and watchdog ----------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_took <= 1'b0;
         rx_phase = ymr_pkg::PH_WAIT; hdr_part = ymr_pkg::HF_NAME;
         blk_long = 0; hdr_done = 0; seq_ok = 0; begun = 0; closed = 0;
         blk_pos = 0; seq_got = 0; seq_want = 0; err_run = 0;
         crc_calc = 0; crc_sent = 0; size_parsed = 0; part_count = 0;
         base_addr = 0; capacity = 25'h1000000; err_limit = 8'd5; flash_ptr = 0;
      end else begin
         cycles++;
         req_took <= req_tvalid && req_tready;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ymr_pkg::CSR_START: begin
                  base_addr = csr_data[23:0]; flash_ptr = csr_data[23:0];
               end
               ymr_pkg::CSR_CAP:   capacity = csr_data[24:0];
               ymr_pkg::CSR_MAXE:  err_limit = csr_data[7:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            predict(req_tuser, req_tdata);
            foreach (step_beats[i]) awaited.push_back(step_beats[i]);
            items_sent++;
         end
         if (rsp_tvalid && rsp_tready) check_beat();
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else if (++quiet_cycles >= 4000) begin
            $display("%0t: no traffic for %0d cycles", $time, quiet_cycles);
            $display("FAILURE");
            $finish;
         end
      end
   end

   // --- drivers -------------------------------------------------------------
   function automatic logic random_gap();
      // one long stretch without stalls on either side
      return !(cycles >= 200 && cycles < 400) && ($urandom_range(0, 99) < 10);
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= !random_gap();
         if (!req_tvalid || req_took) begin
            if (pending.size() > 0 && !random_gap()) begin
               next_item = pending.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= next_item[0];
               req_tdata <= next_item[8:1];
            end else req_tvalid <= 1'b0;
         end
      end
   end

   // --- stimulus helpers ----------------------------------------------------
   task automatic queue_byte(logic [7:0] b);
      pending.push_back({b, 1'b0});
      queued++;
   endtask

   task automatic send_tick();
      logic [7:0] junk;
      junk = 8'($urandom);
      pending.push_back({junk, 1'b1});
      queued++;
   endtask

   // packet from body[], padded with random bytes; cut > 0 stops early with a timeout
   task automatic send_packet(logic lng, logic [7:0] seq, logic bad_cmp, logic bad_crc,
                              int cut);
      int          len;
      logic [15:0] c;
      logic [7:0]  b;
      len = lng ? ymr_pkg::LONG_BLOCK_BYTES : ymr_pkg::SHORT_BLOCK_BYTES;
      c = '0;
      queue_byte(lng ? ymr_pkg::B_STX : ymr_pkg::B_SOH);
      queue_byte(seq);
      queue_byte(bad_cmp ? ~seq ^ 8'h10 : ~seq);
      for (int i = 0; i < len; i++) begin
         if (cut > 0 && i == cut) begin
            send_tick();
            body.delete();
            return;
         end
         b = (i < body.size()) ? body[i] : 8'($urandom);
         c = crc16_step(c, b);
         queue_byte(b);
      end
      if (bad_crc) c ^= 16'(1 << $urandom_range(0, 15));
      queue_byte(c[15:8]);
      queue_byte(c[7:0]);
      body.delete();
   endtask

   // header body: name bytes, separator, decimal size text, a space, trailing zeros
   task automatic make_header(int name_len, string size_txt);
      body.delete();
      for (int i = 0; i < name_len; i++) body.push_back(8'($urandom_range("a", "z")));
      body.push_back(8'h00);
      for (int i = 0; i < size_txt.len(); i++) body.push_back(size_txt[i]);
      body.push_back(8'h20);
      while (body.size() < ymr_pkg::SHORT_BLOCK_BYTES) body.push_back(8'h00);
   endtask

   task automatic settle();
      while (pending.size() > 0 || req_tvalid || awaited.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // --- test sequence -------------------------------------------------------
   initial begin
      int unsigned fsize, ending, budget, pick, off;
      logic [7:0]  seq;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // one file with full capacity and the largest error limit
      csr_write(ymr_pkg::CSR_START, 32'($urandom_range(0, 16'hffff)));
      csr_write(ymr_pkg::CSR_CAP, 32'h0100_0000);
      csr_write(ymr_pkg::CSR_MAXE, 32'd255);

      // the two endings that need a whole header packet leave less room for faults
      ending = $urandom_range(0, 4);
      budget = (ending == 0 || ending == 3) ? 270 : 400;

      // errors and oddities before any session
      send_tick();
      queue_byte(8'hff);
      queue_byte(8'h00);
      queue_byte(ymr_pkg::B_CA);
      queue_byte(8'h00);
      queue_byte(ymr_pkg::B_EOT);

      fsize = $urandom_range(1, 200);
      make_header($urandom_range(1, 40), $sformatf("%0d", fsize));
      send_packet(1'b0, 8'h00, 1'b0, 1'b0, 0);
      send_packet(1'b0, 8'h01, 1'b0, 1'b0, 0);
      seq = 8'd2;
      off = ymr_pkg::SHORT_BLOCK_BYTES;

      // mixed faults and packets, some lying past the size
      while (queued < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            send_packet(1'b0, seq, 1'b0, 1'b0, 0);
            seq++; off += ymr_pkg::SHORT_BLOCK_BYTES;
         end else if (pick < 33) begin
            send_packet(1'b0, seq, 1'b0, 1'b1, 0);
            if (off >= fsize) begin
               seq++; off += ymr_pkg::SHORT_BLOCK_BYTES;
            end
         end else if (pick < 39) send_packet(1'b0, 8'(seq - 8'd1), 1'b0, 1'b0, 0);
         else if (pick < 45) send_packet(1'b0, seq, 1'b1, 1'b0, 0);
         else if (pick < 70) send_packet(1'b0, seq, 1'b0, 1'b0, $urandom_range(1, 8));
         else if (pick < 85) queue_byte(8'($urandom_range(8'h80, 8'hff)));
         else begin
            queue_byte(ymr_pkg::B_CA);
            queue_byte(8'($urandom_range(8'h30, 8'h39)));
         end
      end
      queue_byte(ymr_pkg::B_EOT);
      settle();

      // closing session: smallest flash, no error tolerance
      csr_write(ymr_pkg::CSR_START, 32'd0);
      csr_write(ymr_pkg::CSR_CAP, 32'd1);
      csr_write(ymr_pkg::CSR_MAXE, 32'd0);
      case (ending)
         0: begin
            body.delete(); body.push_back(8'h00);
            send_packet(1'b0, 8'h00, 1'b0, 1'b0, 0);
         end
         1: begin queue_byte(ymr_pkg::B_CA); queue_byte(ymr_pkg::B_CA); end
         2: send_tick();
         3: begin
            make_header(3, "99999999999999999999");
            send_packet(1'b0, 8'h00, 1'b0, 1'b0, 0);
         end
         default: queue_byte($urandom_range(0, 1) ? ymr_pkg::B_ABU : ymr_pkg::B_ABL);
      endcase
      // after the session has closed nothing more may come out
      repeat (6) begin
         if ($urandom_range(0, 1)) send_tick();
         else queue_byte(8'($urandom));
      end
      settle();
      repeat (20) @(posedge clock);

      $display("Ran %0d input beats through one file and a closing session, %0d result beats.",
               items_sent, beats_checked);
      $display("Session closed through ending %0d; %0d mismatches.", ending, errors);
      if (errors == 0 && awaited.size() == 0) begin
         $display("SUCCESS");
      end else begin
         if (awaited.size() != 0) $display("%0d expected beats never arrived", awaited.size());
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* ymodem_crc_packet_receiver.f */
sv/ymr_pkg.sv
sv/ymr_front.sv
sv/ymr_back.sv
sv/ymodem_crc_packet_receiver.sv
bench/testbench.sv
